// ===== rtl/sslb_pkg.sv =====
// ----------------------------------------------------------------------------
// sslb_pkg
// Shared widths, codes, types and sector helpers of the speed limit blender.
// ----------------------------------------------------------------------------
package sslb_pkg;

   localparam int RATE_BITS      = 21;
   localparam int FULL_TURN      = 36000;
   localparam int ANGLE_BITS     = 16;
   localparam int NUM_SECTORS    = 4;
   localparam int SECTOR_BITS    = 2;
   localparam int TABLE_BITS     = 3 * RATE_BITS;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int BOOST_BITS     = 16;
   localparam int BOOST_FRAC     = 8;
   localparam int BOOST_ONE      = 256;
   localparam int LOOK_MIN       = 10;
   localparam int GD_BITS        = 2 * ANGLE_BITS;
   localparam int GN_BITS        = RATE_BITS + GD_BITS;
   localparam int DIV_NUM_BITS   = GN_BITS + 2;
   localparam int DIV_DEN_BITS   = GD_BITS + 1;
   localparam int PROD_BITS      = RATE_BITS + BOOST_BITS;
   localparam int SECTOR_VEC     = NUM_SECTORS * ANGLE_BITS;

   localparam logic [ANGLE_BITS:0] TURN = (ANGLE_BITS + 1)'(FULL_TURN);

   typedef logic [ANGLE_BITS-1:0] angle_type;
   typedef logic [RATE_BITS-1:0]  rate_type;

   typedef enum logic [1:0] {
      SPEED_SLOW,
      SPEED_MEDIUM,
      SPEED_FAST
   } prof_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SECTOR_STARTS,
      CSR_SECTOR_ENDS,
      CSR_LOOKAHEAD,
      CSR_DECEL_BOOST,
      CSR_SPEED_TABLE,
      CSR_ACCEL_TABLE,
      CSR_JERK_TABLE
   } csr_index_type;

   typedef struct packed {
      logic                   hit;
      logic [SECTOR_BITS-1:0] idx;
   } sector_hit_type;

   typedef struct packed {
      rate_type accel_limit;
      rate_type jerk_limit;
   } limit_type;

   // angle is below twice a full turn
   function automatic angle_type mod_turn(angle_type a);
      logic [ANGLE_BITS:0] wide;
      wide = {1'b0, a};
      if (wide >= TURN) begin
         return ANGLE_BITS'(wide - TURN);
      end
      return a;
   endfunction

   function automatic logic in_sector(angle_type a, angle_type s, angle_type e);
      if (e < s) begin
         return (a >= s) || (a <= e);
      end
      return (a >= s) && (a <= e);
   endfunction

   function automatic angle_type dist_to(angle_type from, angle_type s, angle_type e);
      angle_type sn;
      sn = mod_turn(s);
      if (e < s) begin
         if ((from <= e) || (from >= sn)) begin
            return '0;
         end
         return sn - from;
      end
      if ((from >= s) && (from <= e)) begin
         return '0;
      end
      if (from < s) begin
         return s - from;
      end
      return ANGLE_BITS'(TURN - {1'b0, from} + {1'b0, s});
   endfunction

   function automatic rate_type tab_field(logic [TABLE_BITS-1:0] t, prof_type p);
      rate_type r;
      unique case (p)
         SPEED_SLOW:   r = t[0 +: RATE_BITS];
         SPEED_MEDIUM: r = t[RATE_BITS +: RATE_BITS];
         SPEED_FAST:   r = t[2*RATE_BITS +: RATE_BITS];
         default:      r = t[0 +: RATE_BITS];
      endcase
      return r;
   endfunction

   // up slow, medium medium, down slow, travel fast, none slow
   function automatic prof_type sector_profile(sector_hit_type h);
      prof_type p;
      unique case (h.idx)
         2'd0:    p = SPEED_SLOW;
         2'd1:    p = SPEED_MEDIUM;
         2'd2:    p = SPEED_SLOW;
         default: p = SPEED_FAST;
      endcase
      return h.hit ? p : SPEED_SLOW;
   endfunction

   // first sector holding the angle wins
   function automatic sector_hit_type find_sector(angle_type a,
                                                  logic [SECTOR_VEC-1:0] starts,
                                                  logic [SECTOR_VEC-1:0] ends);
      sector_hit_type r;
      r = '0;
      for (int i = NUM_SECTORS - 1; i >= 0; i--) begin
         if (in_sector(a, starts[i*ANGLE_BITS +: ANGLE_BITS],
                       ends[i*ANGLE_BITS +: ANGLE_BITS])) begin
            r.hit = 1'b1;
            r.idx = SECTOR_BITS'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/sslb_req_if.sv =====
// ----------------------------------------------------------------------------
// sslb_req_if
// Input item channel: shaft angle and present step rate.
// ----------------------------------------------------------------------------
interface sslb_req_if import sslb_pkg::*; ();

   logic      valid;
   logic      ready;
   angle_type shaft_angle;
   rate_type  present_rate;

   modport source (output valid, output shaft_angle, output present_rate, input ready);
   modport sink (input valid, input shaft_angle, input present_rate, output ready);

endinterface

// ===== rtl/sslb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sslb_rsp_if
// Result item channel: acceleration and jerk limits and rate goal.
// ----------------------------------------------------------------------------
interface sslb_rsp_if import sslb_pkg::*; ();

   logic     valid;
   logic     ready;
   rate_type accel_limit;
   rate_type jerk_limit;
   rate_type rate_goal;

   modport source (output valid, output accel_limit, output jerk_limit,
                   output rate_goal, input ready);
   modport sink (input valid, input accel_limit, input jerk_limit,
                 input rate_goal, output ready);

endinterface

// ===== rtl/sslb_csr_if.sv =====
// ----------------------------------------------------------------------------
// sslb_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sslb_csr_if import sslb_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);

endinterface

// ===== rtl/sector_speed_limit_blender.sv =====
// ----------------------------------------------------------------------------
// sector_speed_limit_blender
// Sector lookup, speed blending and braking boost of acceleration limits.
// ----------------------------------------------------------------------------
// One item enters per clock while the skid register is empty; each passes
// seven stages of sector lookup, blending and wide multiplies, one stage per
// goal bit in the rounding divider (RATE_BITS of them), then the output
// register. A result not taken moves into a skid register; input is refused
// only while both the output and the skid register are full. Registers must
// be written only while the block holds no items; it is not enforced.
module sector_speed_limit_blender import sslb_pkg::*; (
   input logic        clock,
   input logic        reset,
   sslb_req_if.sink   req_bus,
   sslb_rsp_if.source rsp_bus,
   sslb_csr_if.sink   csr_bus
);

   // registers
   logic [SECTOR_VEC-1:0] starts_ff, starts_in;
   logic [SECTOR_VEC-1:0] ends_ff, ends_in;
   angle_type             look_ff, look_in;
   logic [BOOST_BITS-1:0] boost_ff, boost_in;
   logic [TABLE_BITS-1:0] speed_ff, speed_in;
   logic [TABLE_BITS-1:0] accel_ff, accel_in;
   logic [TABLE_BITS-1:0] jerk_ff, jerk_in;

   logic advance;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      starts_in = starts_ff;
      ends_in   = ends_ff;
      look_in   = look_ff;
      boost_in  = boost_ff;
      speed_in  = speed_ff;
      accel_in  = accel_ff;
      jerk_in   = jerk_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_SECTOR_STARTS: starts_in = csr_bus.data[SECTOR_VEC-1:0];
            CSR_SECTOR_ENDS:   ends_in   = csr_bus.data[SECTOR_VEC-1:0];
            CSR_LOOKAHEAD:     look_in   = csr_bus.data[ANGLE_BITS-1:0];
            CSR_DECEL_BOOST:   boost_in  = csr_bus.data[BOOST_BITS-1:0];
            CSR_SPEED_TABLE:   speed_in  = csr_bus.data[TABLE_BITS-1:0];
            CSR_ACCEL_TABLE:   accel_in  = csr_bus.data[TABLE_BITS-1:0];
            CSR_JERK_TABLE:    jerk_in   = csr_bus.data[TABLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         starts_ff <= '0;
         ends_ff   <= '0;
         look_ff   <= '0;
         boost_ff  <= BOOST_BITS'(BOOST_ONE);
         speed_ff  <= '0;
         accel_ff  <= '0;
         jerk_ff   <= '0;
      end else begin
         starts_ff <= starts_in;
         ends_ff   <= ends_in;
         look_ff   <= look_in;
         boost_ff  <= boost_in;
         speed_ff  <= speed_in;
         accel_ff  <= accel_in;
         jerk_ff   <= jerk_in;
      end
   end

   // stage a: angle reduced to one turn
   logic      a_valid_ff;
   angle_type a_angle_ff, a_angle_in;
   rate_type  a_rate_ff;

   assign a_angle_in = mod_turn(req_bus.shaft_angle);

   // stage b: sector lookup, distance to next sector and its profile
   logic           b_valid_ff;
   sector_hit_type b_hit_ff, b_hit_in;
   angle_type      b_dist_ff, b_dist_in;
   prof_type       b_next_prof_ff, b_next_prof_in;
   rate_type       b_rate_ff;
   prof_type       next_prof [NUM_SECTORS];
   angle_type      dist_all  [NUM_SECTORS];
   logic [SECTOR_BITS-1:0] nxt;

   always_comb begin
      for (int i = 0; i < NUM_SECTORS; i++) begin
         next_prof[i] = sector_profile(find_sector(starts_ff[i*ANGLE_BITS +: ANGLE_BITS],
                                                   starts_ff, ends_ff));
         dist_all[i]  = dist_to(a_angle_ff, starts_ff[i*ANGLE_BITS +: ANGLE_BITS],
                                ends_ff[i*ANGLE_BITS +: ANGLE_BITS]);
      end
      b_hit_in       = find_sector(a_angle_ff, starts_ff, ends_ff);
      nxt            = b_hit_in.idx + 1'b1;
      b_dist_in      = dist_all[nxt];
      b_next_prof_in = next_prof[nxt];
   end

   // stage c: profile tables and blend decision
   logic      c_valid_ff;
   rate_type  c_rate_ff;
   rate_type  c_acc_ff, c_acc_in;
   rate_type  c_jerk_ff, c_jerk_in;
   rate_type  c_vnow_ff, c_vnow_in;
   rate_type  c_diff_ff, c_diff_in;
   angle_type c_num_ff, c_num_in;
   logic      c_blend_ff, c_blend_in;
   logic      c_fall_ff, c_fall_in;
   prof_type  cur_prof;
   rate_type  vnext;

   always_comb begin
      cur_prof   = sector_profile(b_hit_ff);
      c_acc_in   = tab_field(accel_ff, cur_prof);
      c_jerk_in  = tab_field(jerk_ff, cur_prof);
      c_vnow_in  = tab_field(speed_ff, cur_prof);
      vnext      = tab_field(speed_ff, b_next_prof_ff);
      c_fall_in  = vnext < c_vnow_in;
      c_diff_in  = c_fall_in ? c_vnow_in - vnext : vnext - c_vnow_in;
      c_num_in   = look_ff - b_dist_ff;
      c_blend_in = b_hit_ff.hit && (look_ff > ANGLE_BITS'(LOOK_MIN)) &&
                   (b_dist_ff != '0) && (vnext != c_vnow_in) && (b_dist_ff <= look_ff);
   end

   // stage d: squares and boost product
   logic                  d_valid_ff;
   rate_type              d_rate_ff, d_acc_ff, d_jerk_ff, d_vnow_ff, d_diff_ff;
   angle_type             d_num_ff;
   logic                  d_blend_ff, d_fall_ff;
   logic [GD_BITS-1:0]    d_look_sq_ff, d_look_sq_in;
   logic [GD_BITS-1:0]    d_num_sq_ff, d_num_sq_in;
   logic [PROD_BITS-1:0]  d_prod_ff, d_prod_in;

   always_comb begin
      d_look_sq_in = GD_BITS'(look_ff) * GD_BITS'(look_ff);
      d_num_sq_in  = GD_BITS'(c_num_ff) * GD_BITS'(c_num_ff);
      d_prod_in    = PROD_BITS'(c_acc_ff) * PROD_BITS'(boost_ff);
   end

   // stage e: goal numerator terms over the common denominator
   logic                 e_valid_ff;
   rate_type             e_acc_ff, e_jerk_ff;
   rate_type             e_acc_sat_ff, e_acc_sat_in;
   logic                 e_fall_ff;
   logic [GN_BITS-1:0]   e_base_ff, e_base_in;
   logic [GN_BITS-1:0]   e_adj_ff, e_adj_in;
   logic [GN_BITS-1:0]   e_rgd_ff, e_rgd_in;
   logic [GD_BITS-1:0]   e_gd_ff, e_gd_in;
   logic [GD_BITS-1:0]   nsq;
   logic [PROD_BITS-BOOST_FRAC-1:0] boosted;

   always_comb begin
      priority if (!d_blend_ff) begin
         e_gd_in = GD_BITS'(1);
         nsq     = '0;
      end else if (d_fall_ff) begin
         e_gd_in = d_look_sq_ff;
         nsq     = d_num_sq_ff;
      end else begin
         e_gd_in = GD_BITS'(look_ff);
         nsq     = GD_BITS'(d_num_ff);
      end
      e_base_in    = GN_BITS'(d_vnow_ff) * GN_BITS'(e_gd_in);
      e_adj_in     = GN_BITS'(d_diff_ff) * GN_BITS'(nsq);
      e_rgd_in     = GN_BITS'(d_rate_ff) * GN_BITS'(e_gd_in);
      boosted      = d_prod_ff[PROD_BITS-1:BOOST_FRAC];
      e_acc_sat_in = (|boosted[PROD_BITS-BOOST_FRAC-1:RATE_BITS]) ? '1 :
                     boosted[RATE_BITS-1:0];
   end

   // stage f: exact goal numerator
   logic               f_valid_ff;
   rate_type           f_acc_ff, f_jerk_ff, f_acc_sat_ff;
   logic [GN_BITS-1:0] f_gn_ff, f_gn_in;
   logic [GN_BITS-1:0] f_rgd_ff;
   logic [GD_BITS-1:0] f_gd_ff;

   assign f_gn_in = e_fall_ff ? e_base_ff - e_adj_ff : e_base_ff + e_adj_ff;

   // stage g: braking test and rounding divider operands
   logic                    g_valid_ff;
   limit_type               g_side_ff, g_side_in;
   logic [DIV_NUM_BITS-1:0] g_num_ff, g_num_in;
   logic [DIV_DEN_BITS-1:0] g_den_ff, g_den_in;
   logic                    brake;

   always_comb begin
      brake                 = (f_rgd_ff > f_gn_ff) && (boost_ff > BOOST_BITS'(BOOST_ONE));
      g_side_in.accel_limit = brake ? f_acc_sat_ff : f_acc_ff;
      g_side_in.jerk_limit  = f_jerk_ff;
      g_num_in              = DIV_NUM_BITS'({f_gn_ff, 1'b0}) + DIV_NUM_BITS'(f_gd_ff);
      g_den_in              = {f_gd_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_bus.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_angle_ff     <= a_angle_in;
         a_rate_ff      <= req_bus.present_rate;
         b_hit_ff       <= b_hit_in;
         b_dist_ff      <= b_dist_in;
         b_next_prof_ff <= b_next_prof_in;
         b_rate_ff      <= a_rate_ff;
         c_rate_ff      <= b_rate_ff;
         c_acc_ff       <= c_acc_in;
         c_jerk_ff      <= c_jerk_in;
         c_vnow_ff      <= c_vnow_in;
         c_diff_ff      <= c_diff_in;
         c_num_ff       <= c_num_in;
         c_blend_ff     <= c_blend_in;
         c_fall_ff      <= c_fall_in;
         d_rate_ff      <= c_rate_ff;
         d_acc_ff       <= c_acc_ff;
         d_jerk_ff      <= c_jerk_ff;
         d_vnow_ff      <= c_vnow_ff;
         d_diff_ff      <= c_diff_ff;
         d_num_ff       <= c_num_ff;
         d_blend_ff     <= c_blend_ff;
         d_fall_ff      <= c_fall_ff;
         d_look_sq_ff   <= d_look_sq_in;
         d_num_sq_ff    <= d_num_sq_in;
         d_prod_ff      <= d_prod_in;
         e_acc_ff       <= d_acc_ff;
         e_jerk_ff      <= d_jerk_ff;
         e_acc_sat_ff   <= e_acc_sat_in;
         e_fall_ff      <= d_blend_ff && d_fall_ff;
         e_base_ff      <= e_base_in;
         e_adj_ff       <= e_adj_in;
         e_rgd_ff       <= e_rgd_in;
         e_gd_ff        <= e_gd_in;
         f_acc_ff       <= e_acc_ff;
         f_jerk_ff      <= e_jerk_ff;
         f_acc_sat_ff   <= e_acc_sat_ff;
         f_gn_ff        <= f_gn_in;
         f_rgd_ff       <= e_rgd_ff;
         f_gd_ff        <= e_gd_ff;
         g_side_ff      <= g_side_in;
         g_num_ff       <= g_num_in;
         g_den_ff       <= g_den_in;
      end
   end

   // rounding divider
   logic      div_valid;
   rate_type  div_quot;
   limit_type div_side;

   sslb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (g_valid_ff),
      .in_num    (g_num_ff),
      .in_den    (g_den_ff),
      .in_side   (g_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // output register and skid register
   logic      out_valid_ff, out_valid_in;
   limit_type out_side_ff, out_side_in;
   rate_type  out_goal_ff, out_goal_in;
   logic      skid_valid_ff, skid_valid_in;
   limit_type skid_side_ff, skid_side_in;
   rate_type  skid_goal_ff, skid_goal_in;
   logic      out_take;

   assign out_take      = out_valid_ff && rsp_bus.ready;
   assign advance       = !skid_valid_ff;
   assign req_bus.ready = advance;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_side_in   = out_side_ff;
      out_goal_in   = out_goal_ff;
      skid_valid_in = skid_valid_ff;
      skid_side_in  = skid_side_ff;
      skid_goal_in  = skid_goal_ff;
      priority if (skid_valid_ff) begin
         if (out_take) begin
            out_side_in   = skid_side_ff;
            out_goal_in   = skid_goal_ff;
            skid_valid_in = 1'b0;
         end
      end else if (div_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_side_in  = div_side;
            out_goal_in  = div_quot;
         end else begin
            skid_valid_in = 1'b1;
            skid_side_in  = div_side;
            skid_goal_in  = div_quot;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_side_ff  <= out_side_in;
      out_goal_ff  <= out_goal_in;
      skid_side_ff <= skid_side_in;
      skid_goal_ff <= skid_goal_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.accel_limit = out_side_ff.accel_limit;
   assign rsp_bus.jerk_limit  = out_side_ff.jerk_limit;
   assign rsp_bus.rate_goal   = out_goal_ff;

endmodule

// ===== rtl/sslb_div.sv =====
// ----------------------------------------------------------------------------
// sslb_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module sslb_div import sslb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic [DIV_NUM_BITS-1:0] in_num,
   input  logic [DIV_DEN_BITS-1:0] in_den,
   input  limit_type               in_side,
   output logic                    out_valid,
   output rate_type                out_quot,
   output limit_type               out_side
);

   logic                    valid_ff [RATE_BITS];
   logic [DIV_NUM_BITS-1:0] rem_ff   [RATE_BITS];
   logic [DIV_DEN_BITS-1:0] den_ff   [RATE_BITS];
   rate_type                quot_ff  [RATE_BITS];
   limit_type               side_ff  [RATE_BITS];

   genvar k;
   for (k = 0; k < RATE_BITS; k++) begin : g_stage
      logic                    src_valid;
      logic [DIV_NUM_BITS-1:0] src_rem;
      logic [DIV_DEN_BITS-1:0] src_den;
      rate_type                src_quot;
      limit_type               src_side;
      logic [DIV_NUM_BITS-1:0] shifted;
      logic [DIV_NUM_BITS-1:0] rem_in;
      rate_type                quot_in;
      logic                    ge;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_num;
         assign src_den   = in_den;
         assign src_quot  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      always_comb begin
         shifted = DIV_NUM_BITS'(src_den) << (RATE_BITS - 1 - k);
         ge      = src_rem >= shifted;
         rem_in  = ge ? src_rem - shifted : src_rem;
         quot_in = src_quot;
         quot_in[RATE_BITS-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= src_den;
            quot_ff[k] <= quot_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[RATE_BITS-1];
   assign out_quot  = quot_ff[RATE_BITS-1];
   assign out_side  = side_ff[RATE_BITS-1];

endmodule

// ===== rtl/sslb_chk.sv =====
// ----------------------------------------------------------------------------
// sslb_chk
// Port checker of the speed limit blender, bound to the top level.
// ----------------------------------------------------------------------------
module sslb_chk import sslb_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input rate_type rsp_accel_limit,
   input rate_type rsp_jerk_limit,
   input rate_type rsp_rate_goal
);

   // items taken but not yet delivered
   logic [7:0] pending_ff, pending_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 8'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 8'd0))
      else $error("result without a pending item");

   a_refuse_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input refused with no result waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accel_limit) &&
      $stable(rsp_jerk_limit) && $stable(rsp_rate_goal))
      else $error("stalled result changed");

endmodule

bind sector_speed_limit_blender sslb_chk u_sslb_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_accel_limit (rsp_bus.accel_limit),
   .rsp_jerk_limit  (rsp_bus.jerk_limit),
   .rsp_rate_goal   (rsp_bus.rate_goal)
);
